// File: sv/text_window_console_assert.svh
// assertion macros used by the checker file
`ifndef TEXT_WINDOW_CONSOLE_ASSERT_SVH
`define TEXT_WINDOW_CONSOLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define TWC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text window console check failed");

// next-cycle implication, sampled on clk, off during rst
`define TWC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text window console check failed");

`endif

// File: sv/twc_pkg.sv
// types and constants of the text window console
package twc_pkg;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_MOVE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_code;
    logic [6:0]  col;
    logic [4:0]  row;
  } cmd_t;

  typedef struct packed {
    logic [15:0] cell_word;
    logic [6:0]  cursor_col_out;
    logic [4:0]  cursor_row_out;
    logic        rejected;
  } result_t;

  // register indexes of the configuration channel
  localparam logic [2:0] CFG_WIN_LEFT     = 3'd0;
  localparam logic [2:0] CFG_WIN_TOP      = 3'd1;
  localparam logic [2:0] CFG_WIN_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_WIN_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_TEXT_COLOR   = 3'd4;
  localparam logic [2:0] CFG_CURSOR_GLYPH = 3'd5;

  // register reset values
  localparam logic [6:0] RST_WIN_WIDTH    = 7'd80;
  localparam logic [4:0] RST_WIN_HEIGHT   = 5'd25;
  localparam logic [7:0] RST_TEXT_COLOR   = 8'h0f;
  localparam logic [7:0] RST_CURSOR_GLYPH = 8'h20;

  // control characters
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_BS = 8'd8;

  localparam logic [15:0] BLANK_CELL = 16'h0020;

endpackage

// File: sv/text_window_console.sv
// top level of the text window console: cursor sequencer around the screen ram
//
// usage
//   command channel: a command transfers at a clock edge where start is high and
//   busy is low. kinds are put character, read cell, clear window, move cursor.
//   every command gives one result, shown for exactly one cycle with done high;
//   the receiver cannot hold it off, so it must take it in that cycle.
//   config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, ready is
//   always high; write only while no command is outstanding.
// command steps
//   move cursor: result registered at the transfer. read cell: one ram read.
//   put character: cell write, then cursor draw (one ram write port).
//   put character that scrolls: cell write, window rows copied up, bottom row zeroed,
//   then cursor draw, one cell copied or zeroed per cycle through the ram; no copy when h is 1.
//   clear window: one cell zeroed per cycle, then cursor draw.
//   busy is low again in the cycle that shows done, so the done cycle of one
//   command can be the transfer of the next.
// reset
//   rst is synchronous. after it the block sweeps the whole screen ram to zero,
//   one cell per cycle with busy high; config writes are taken during the sweep.
module text_window_console
  import twc_pkg::*;
#(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd,
  output logic       done,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int DEPTH = SCREEN_COLS * SCREEN_ROWS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_PUT, ST_SCROLL, ST_DRAIN, ST_ZERO, ST_CLEAR, ST_DRAW, ST_RWAIT
  } state_t;

  state_t state;

  // config registers
  logic [6:0] win_left;
  logic [4:0] win_top;
  logic [6:0] win_width;
  logic [4:0] win_height;
  logic [7:0] text_color;
  logic [7:0] cursor_glyph;

  // cursor and sequencer registers
  logic [6:0]    cur_col;
  logic [4:0]    cur_row;
  cmd_t          cmd_q;
  logic [6:0]    sx;
  logic [4:0]    sy;
  logic [AW-1:0] init_cnt;
  logic          rd_ok;

  // pending scroll write, done in the cycle after its read
  logic          pend_v;
  logic          pend_wok;
  logic          pend_rok;
  logic [AW-1:0] pend_waddr;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  // window size, zero acts as one
  logic [6:0] w_eff;
  logic [4:0] h_eff;

  // write coordinate mux for the cell-walking states
  logic [7:0]  wx;
  logic [5:0]  wy;
  logic [15:0] wval;
  logic        wreq;

  // read coordinates
  logic [7:0] rx;
  logic [5:0] ry;

  // scroll write coordinates
  logic [7:0] sw_x;
  logic [5:0] sw_y;

  // put character next cursor
  logic       is_nl;
  logic       is_bs;
  logic [7:0] col_inc;
  logic [5:0] row_inc;
  logic [6:0] ncol;
  logic [5:0] nrow;
  logic       need_scroll;

  logic accept;

  function automatic logic [AW-1:0] cell_addr(logic [7:0] x, logic [5:0] y);
    return AW'(y) * AW'(SCREEN_COLS) + AW'(x);
  endfunction

  function automatic logic on_screen(logic [7:0] x, logic [5:0] y);
    return (int'(x) < SCREEN_COLS) && (int'(y) < SCREEN_ROWS);
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  assign w_eff = (win_width == 7'd0) ? 7'd1 : win_width;
  assign h_eff = (win_height == 5'd0) ? 5'd1 : win_height;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      win_left     <= '0;
      win_top      <= '0;
      win_width    <= RST_WIN_WIDTH;
      win_height   <= RST_WIN_HEIGHT;
      text_color   <= RST_TEXT_COLOR;
      cursor_glyph <= RST_CURSOR_GLYPH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIN_LEFT:     win_left     <= cfg_data[6:0];
        CFG_WIN_TOP:      win_top      <= cfg_data[4:0];
        CFG_WIN_WIDTH:    win_width    <= cfg_data[6:0];
        CFG_WIN_HEIGHT:   win_height   <= cfg_data[4:0];
        CFG_TEXT_COLOR:   text_color   <= cfg_data;
        CFG_CURSOR_GLYPH: cursor_glyph <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // put character: new cursor position and the need for a scroll
  always_comb begin
    is_nl   = (cmd_q.char_code == CH_LF) || (cmd_q.char_code == CH_CR);
    is_bs   = (cmd_q.char_code == CH_BS);
    col_inc = {1'b0, cur_col} + 8'd1;
    row_inc = {1'b0, cur_row} + 6'd1;
    ncol    = cur_col;
    nrow    = {1'b0, cur_row};
    if (is_nl) begin
      ncol = '0;
      nrow = row_inc;
    end else if (is_bs) begin
      if (cur_col != 7'd0) begin
        ncol = cur_col - 7'd1;
      end else if (cur_row != 5'd0) begin
        // wrap to the end of the previous line
        ncol = w_eff - 7'd1;
        nrow = {1'b0, cur_row - 5'd1};
      end
    end else if (col_inc >= {1'b0, w_eff}) begin
      ncol = '0;
      nrow = row_inc;
    end else begin
      ncol = col_inc[6:0];
    end
    need_scroll = (nrow >= {1'b0, h_eff});
  end

  // scroll walk: read row sy+1, write row sy in the following cycle
  assign rx   = (state == ST_SCROLL) ? ({1'b0, win_left} + {1'b0, sx}) : {1'b0, cmd.col};
  assign ry   = (state == ST_SCROLL) ? ({1'b0, win_top} + {1'b0, sy} + 6'd1)
                                     : {1'b0, cmd.row};
  assign sw_x = {1'b0, win_left} + {1'b0, sx};
  assign sw_y = {1'b0, win_top} + {1'b0, sy};
  assign ram_raddr = cell_addr(rx, ry);

  // write port
  always_comb begin
    wx   = {1'b0, win_left} + {1'b0, cur_col};
    wy   = {1'b0, win_top} + {1'b0, cur_row};
    wval = '0;
    wreq = 1'b0;
    unique case (state)
      ST_PUT: begin
        // blanking and storing hit the same cell, only the last value counts
        wreq = 1'b1;
        wval = (is_nl || is_bs) ? BLANK_CELL : {text_color, cmd_q.char_code};
      end
      ST_DRAW: begin
        wreq = 1'b1;
        wval = {text_color, cursor_glyph};
      end
      ST_ZERO: begin
        wreq = 1'b1;
        wx   = {1'b0, win_left} + {1'b0, sx};
        wy   = {1'b0, win_top} + {1'b0, h_eff - 5'd1};
      end
      ST_CLEAR: begin
        wreq = 1'b1;
        wx   = {1'b0, win_left} + {1'b0, sx};
        wy   = {1'b0, win_top} + {1'b0, sy};
      end
      default: begin
      end
    endcase

    unique case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_cnt;
        ram_wdata = '0;
      end
      ST_SCROLL, ST_DRAIN: begin
        ram_we    = pend_v && pend_wok;
        ram_waddr = pend_waddr;
        ram_wdata = pend_rok ? ram_rdata : 16'h0000;
      end
      default: begin
        ram_we    = wreq && on_screen(wx, wy);
        ram_waddr = cell_addr(wx, wy);
        ram_wdata = wval;
      end
    endcase
  end

  twc_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      init_cnt <= '0;
      cur_col  <= '0;
      cur_row  <= '0;
      pend_v   <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_INIT: begin
          init_cnt <= init_cnt + AW'(1);
          if (init_cnt == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q <= cmd;
            unique case (cmd.kind)
              KIND_PUT: begin
                state <= ST_PUT;
              end
              KIND_READ: begin
                rd_ok <= on_screen({1'b0, cmd.col}, {1'b0, cmd.row});
                state <= ST_RWAIT;
              end
              KIND_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                sx      <= '0;
                sy      <= '0;
                state   <= ST_CLEAR;
              end
              KIND_MOVE: begin
                done                  <= 1'b1;
                result.cell_word      <= '0;
                if (cmd.col < w_eff && cmd.row < h_eff) begin
                  cur_col               <= cmd.col;
                  cur_row               <= cmd.row;
                  result.cursor_col_out <= cmd.col;
                  result.cursor_row_out <= cmd.row;
                  result.rejected       <= 1'b0;
                end else begin
                  result.cursor_col_out <= cur_col;
                  result.cursor_row_out <= cur_row;
                  result.rejected       <= 1'b1;
                end
              end
            endcase
          end
        end
        ST_PUT: begin
          if (need_scroll) begin
            cur_col <= '0;
            cur_row <= h_eff - 5'd1;
            sx      <= '0;
            sy      <= '0;
            pend_v  <= 1'b0;
            state   <= (h_eff == 5'd1) ? ST_ZERO : ST_SCROLL;
          end else begin
            cur_col <= ncol;
            cur_row <= nrow[4:0];
            state   <= ST_DRAW;
          end
        end
        ST_SCROLL: begin
          pend_v     <= 1'b1;
          pend_rok   <= on_screen(rx, ry);
          pend_wok   <= on_screen(sw_x, sw_y);
          pend_waddr <= cell_addr(sw_x, sw_y);
          if (sx == w_eff - 7'd1) begin
            sx <= '0;
            if (sy == h_eff - 5'd2) begin
              state <= ST_DRAIN;
            end else begin
              sy <= sy + 5'd1;
            end
          end else begin
            sx <= sx + 7'd1;
          end
        end
        ST_DRAIN: begin
          pend_v <= 1'b0;
          sx     <= '0;
          state  <= ST_ZERO;
        end
        ST_ZERO: begin
          if (sx == w_eff - 7'd1) begin
            state <= ST_DRAW;
          end else begin
            sx <= sx + 7'd1;
          end
        end
        ST_CLEAR: begin
          if (sx == w_eff - 7'd1) begin
            sx <= '0;
            if (sy == h_eff - 5'd1) begin
              state <= ST_DRAW;
            end else begin
              sy <= sy + 5'd1;
            end
          end else begin
            sx <= sx + 7'd1;
          end
        end
        ST_DRAW: begin
          done                  <= 1'b1;
          result.cell_word      <= '0;
          result.cursor_col_out <= cur_col;
          result.cursor_row_out <= cur_row;
          result.rejected       <= 1'b0;
          state                 <= ST_IDLE;
        end
        ST_RWAIT: begin
          done                  <= 1'b1;
          result.cell_word      <= rd_ok ? ram_rdata : 16'h0000;
          result.cursor_col_out <= cur_col;
          result.cursor_row_out <= cur_row;
          result.rejected       <= 1'b0;
          state                 <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/twc_ram.sv
// generic simple dual-port ram with registered read
module twc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/twc_checker.sv
// port-level checker for the text window console, with its bind
`include "text_window_console_assert.svh"

module twc_checker
  import twc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input cmd_t    cmd,
  input logic    done,
  input result_t result
);

  // every transfer shows up as either work in progress or a result
  `TWC_ASSERT_NEXT(a_transfer_progress, start && !busy, busy || done)

  // a move is answered in the very next cycle
  `TWC_ASSERT_NEXT(a_move_latency, start && !busy && cmd.kind == KIND_MOVE, done)

  // only a move can be rejected
  `TWC_ASSERT_NOW(a_reject_from_move, done && result.rejected,
                  $past(start && !busy && cmd.kind == KIND_MOVE))

  // only a read returns cell data, after one ram read in the read wait state
  `TWC_ASSERT_NOW(a_cell_from_read, done && result.cell_word != 16'h0000,
                  $past(start && !busy && cmd.kind == KIND_READ, 2))

endmodule

bind text_window_console twc_checker u_twc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);

// File: sim/text_window_console_tb.sv
// self-checking testbench for the text window console: screen mirror, command and config drivers
module text_window_console_tb;
  import twc_pkg::*;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;

  // mirror of the screen ram, the cursor and the window registers; every accepted
  // command is played against it and the report it must give is queued
  class screen_mirror;
    logic [15:0] cells [SCREEN_COLS*SCREEN_ROWS];
    int unsigned cur_col;
    int unsigned cur_row;
    logic [6:0]  left;
    logic [4:0]  top;
    logic [6:0]  width;
    logic [4:0]  height;
    logic [7:0]  color;
    logic [7:0]  glyph;
    result_t     cursor_reports [$];
    int          fails;

    function new();
      foreach (cells[i]) cells[i] = '0;
      cur_col = 0;
      cur_row = 0;
      left    = '0;
      top     = '0;
      width   = RST_WIN_WIDTH;
      height  = RST_WIN_HEIGHT;
      color   = RST_TEXT_COLOR;
      glyph   = RST_CURSOR_GLYPH;
      fails   = 0;
    endfunction

    // writes off the screen are dropped
    function void poke(int unsigned x, int unsigned y, logic [15:0] v);
      if (x < SCREEN_COLS && y < SCREEN_ROWS) cells[y*SCREEN_COLS + x] = v;
    endfunction

    // reads off the screen give zero
    function logic [15:0] peek(int unsigned x, int unsigned y);
      if (x < SCREEN_COLS && y < SCREEN_ROWS) return cells[y*SCREEN_COLS + x];
      return '0;
    endfunction

    function void draw_glyph();
      poke(left + cur_col, top + cur_row, {color, glyph});
    endfunction

    function int outstanding();
      return cursor_reports.size();
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        CFG_WIN_LEFT:     left   = val[6:0];
        CFG_WIN_TOP:      top    = val[4:0];
        CFG_WIN_WIDTH:    width  = val[6:0];
        CFG_WIN_HEIGHT:   height = val[4:0];
        CFG_TEXT_COLOR:   color  = val;
        CFG_CURSOR_GLYPH: glyph  = val;
        default: ;
      endcase
    endfunction

    function void take_cmd(cmd_t c);
      int unsigned w;
      int unsigned h;
      result_t     r;
      // a zero-sized window behaves as one cell wide or tall
      w = (width == 0) ? 1 : width;
      h = (height == 0) ? 1 : height;
      r = '0;
      case (c.kind)
        KIND_PUT: begin
          poke(left + cur_col, top + cur_row, BLANK_CELL);
          if (c.char_code == CH_LF || c.char_code == CH_CR) begin
            cur_col = 0;
            cur_row++;
          end else if (c.char_code == CH_BS) begin
            // backspace wraps to the end of the previous line, stuck at the origin
            if (cur_col != 0) begin
              cur_col--;
            end else if (cur_row != 0) begin
              cur_col = w - 1;
              cur_row--;
            end
          end else begin
            poke(left + cur_col, top + cur_row, {color, c.char_code});
            cur_col++;
            if (cur_col >= w) begin
              cur_col = 0;
              cur_row++;
            end
          end
          // past the last row: shift the window up, blank the bottom row
          if (cur_row >= h) begin
            for (int unsigned y = 0; y + 1 < h; y++)
              for (int unsigned x = 0; x < w; x++)
                poke(left + x, top + y, peek(left + x, top + y + 1));
            for (int unsigned x = 0; x < w; x++)
              poke(left + x, top + h - 1, '0);
            cur_col = 0;
            cur_row = h - 1;
          end
          draw_glyph();
        end
        KIND_READ: r.cell_word = peek(c.col, c.row);
        KIND_CLEAR: begin
          cur_col = 0;
          cur_row = 0;
          for (int unsigned y = 0; y < h; y++)
            for (int unsigned x = 0; x < w; x++)
              poke(left + x, top + y, '0);
          draw_glyph();
        end
        default: begin
          // move: out-of-window targets leave the cursor alone, nothing redrawn
          if (c.col < w && c.row < h) begin
            cur_col = c.col;
            cur_row = c.row;
          end else begin
            r.rejected = 1'b1;
          end
        end
      endcase
      r.cursor_col_out = 7'(cur_col);
      r.cursor_row_out = 5'(cur_row);
      cursor_reports.push_back(r);
    endfunction

    function void match_report(result_t got);
      result_t want;
      if (cursor_reports.size() == 0) begin
        $error("result %h with no command outstanding", got);
        fails++;
        return;
      end
      want = cursor_reports.pop_front();
      if (got.cell_word !== want.cell_word) begin
        $error("cell_word expected %h got %h", want.cell_word, got.cell_word);
        fails++;
      end
      if (got.cursor_col_out !== want.cursor_col_out) begin
        $error("cursor_col_out expected %0d got %0d", want.cursor_col_out, got.cursor_col_out);
        fails++;
      end
      if (got.cursor_row_out !== want.cursor_row_out) begin
        $error("cursor_row_out expected %0d got %0d", want.cursor_row_out, got.cursor_row_out);
        fails++;
      end
      if (got.rejected !== want.rejected) begin
        $error("rejected expected %b got %b", want.rejected, got.rejected);
        fails++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  cmd_t       cmd = '0;
  logic       done;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = CFG_WIN_LEFT;
  logic [7:0] cfg_data = '0;

  screen_mirror mirror = new();

  // chance in percent that the sender idles before a command, drawn again after each idle
  int idle_pct = 0;

  text_window_console #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // all sampling on the rising edge sees pre-edge values; a result is checked
  // before a command of the same edge is noted, since the done cycle and the
  // next transfer may overlap
  always @(posedge clk) begin
    if (!rst) begin
      if (done) mirror.match_report(result);
      if (start && !busy) mirror.take_cmd(cmd);
      if (cfg_valid && cfg_ready) mirror.set_reg(cfg_index, cfg_data);
    end
  end

  // present one command, optionally after idle cycles, and hold it until
  // the transfer; start stays high on return so a following command can go
  // back to back
  task automatic send_cmd(kind_t k, logic [7:0] ch, logic [6:0] c, logic [4:0] r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= '{kind: k, char_code: ch, col: c, row: r};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending and wait until every outstanding result has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // valid stays high across a burst of writes, lowered after the last one
  task automatic write_reg(logic [2:0] idx, logic [7:0] val, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  // registers only change with the block idle
  task automatic set_window(logic [6:0] l, logic [4:0] t, logic [6:0] w, logic [4:0] h,
                            logic [7:0] color, logic [7:0] glyph);
    settle();
    write_reg(CFG_WIN_LEFT, 8'(l), 1'b0);
    write_reg(CFG_WIN_TOP, 8'(t), 1'b0);
    write_reg(CFG_WIN_WIDTH, 8'(w), 1'b0);
    write_reg(CFG_WIN_HEIGHT, 8'(h), 1'b0);
    write_reg(CFG_TEXT_COLOR, color, 1'b0);
    write_reg(CFG_CURSOR_GLYPH, glyph, 1'b1);
  endtask

  // one random command shaped by the current window; big windows get fewer
  // clears since each one walks the whole window
  task automatic random_cmd(logic [6:0] l, logic [4:0] t, int unsigned w, int unsigned h,
                            bit big);
    int unsigned pick;
    logic [7:0]  ch;
    logic [6:0]  c;
    logic [4:0]  r;
    pick = $urandom_range(99);
    ch   = 8'($urandom_range(255));
    c    = 7'($urandom_range(127));
    r    = 5'($urandom_range(31));
    if (pick < 60) begin
      case ($urandom_range(9))
        0: ch = CH_LF;
        1: ch = CH_CR;
        2, 3: ch = CH_BS;
        default: ;
      endcase
      send_cmd(KIND_PUT, ch, c, r);
    end else if (pick < 75) begin
      // mostly around the window, sometimes anywhere the fields reach
      if ($urandom_range(3) != 0) begin
        c = 7'(l + $urandom_range(w + 1));
        r = 5'(t + $urandom_range(h + 1));
      end
      send_cmd(KIND_READ, ch, c, r);
    end else if (pick < (big ? 77 : 80)) begin
      send_cmd(KIND_CLEAR, ch, c, r);
    end else begin
      // targets up to one past the edge so some moves get rejected
      if ($urandom_range(3) != 0) begin
        c = 7'($urandom_range(w));
        r = 5'($urandom_range(h));
      end
      send_cmd(KIND_MOVE, ch, c, r);
    end
  endtask

  // hard stop if the block hangs
  initial begin
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int         pct [4];
    logic [6:0] l;
    logic [4:0] t;
    logic [6:0] w;
    logic [4:0] h;
    logic [7:0] color;
    logic [7:0] glyph;
    int         count;
    bit         big;
    pct = '{0, 69, 0, 36};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // let the power-up sweep of the screen ram run out
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    // directed: default full-screen window
    send_cmd(KIND_READ, 8'h00, 7'd0, 5'd0);
    send_cmd(KIND_READ, 8'hff, 7'd127, 5'd31);        // off the screen
    send_cmd(KIND_PUT, 8'h41, 7'd0, 5'd0);
    send_cmd(KIND_PUT, 8'hff, 7'd127, 5'd31);
    send_cmd(KIND_PUT, 8'h00, 7'd0, 5'd0);
    send_cmd(KIND_PUT, CH_BS, 7'd0, 5'd0);
    send_cmd(KIND_PUT, CH_LF, 7'd0, 5'd0);
    send_cmd(KIND_PUT, CH_CR, 7'd0, 5'd0);
    send_cmd(KIND_READ, 8'h00, 7'd0, 5'd0);
    send_cmd(KIND_MOVE, 8'h00, 7'd79, 5'd24);
    send_cmd(KIND_PUT, 8'h7e, 7'd0, 5'd0);            // wrap at the last cell, full scroll
    send_cmd(KIND_READ, 8'h00, 7'd0, 5'd0);
    send_cmd(KIND_MOVE, 8'h00, 7'd80, 5'd0);          // rejected, column
    send_cmd(KIND_MOVE, 8'h00, 7'd0, 5'd25);          // rejected, row
    send_cmd(KIND_MOVE, 8'h00, 7'd0, 5'd0);
    send_cmd(KIND_PUT, CH_BS, 7'd0, 5'd0);            // backspace at origin stays
    send_cmd(KIND_CLEAR, 8'h00, 7'd0, 5'd0);
    send_cmd(KIND_READ, 8'h00, 7'd0, 5'd0);

    // window hanging past the bottom right corner of the screen
    set_window(7'd76, 5'd22, 7'd8, 5'd5, 8'h00, 8'hff);
    send_cmd(KIND_CLEAR, 8'h00, 7'd0, 5'd0);
    send_cmd(KIND_MOVE, 8'h00, 7'd0, 5'd4);
    send_cmd(KIND_PUT, 8'h7a, 7'd0, 5'd0);            // dropped, off the screen
    // shrink so the cursor ends up outside the window
    set_window(7'd76, 5'd22, 7'd3, 5'd2, 8'hff, 8'h00);
    send_cmd(KIND_PUT, CH_BS, 7'd0, 5'd0);
    send_cmd(KIND_PUT, CH_BS, 7'd0, 5'd0);            // column zero, goes to width-1
    send_cmd(KIND_PUT, 8'h71, 7'd0, 5'd0);            // wrap and scroll from outside
    send_cmd(KIND_READ, 8'h00, 7'd79, 5'd24);

    // random phases; the first few pin register extremes, the rest use small
    // windows anywhere on the screen
    for (int p = 0; p < 14; p++) begin
      color = 8'($urandom_range(255));
      glyph = 8'($urandom_range(255));
      big   = 1'b0;
      count = 140;
      case (p)
        0: begin
          l = 7'd0;   t = 5'd0;  w = 7'd80;  h = 5'd25;
          color = 8'h00; glyph = 8'hff; big = 1'b1; count = 120;
        end
        1: begin
          // zero size acts as a single cell: nearly every put scrolls
          l = 7'd0;   t = 5'd0;  w = 7'd0;   h = 5'd0;
          color = 8'hff; glyph = 8'h00; count = 150;
        end
        2: begin
          l = 7'd79;  t = 5'd24; w = 7'd1;   h = 5'd1;  count = 100;
        end
        3: begin
          // entirely off the screen
          l = 7'd127; t = 5'd31; w = 7'd127; h = 5'd31; big = 1'b1; count = 40;
        end
        4: begin
          l = 7'd0;   t = 5'd0;  w = 7'd127; h = 5'd31; big = 1'b1; count = 40;
        end
        default: begin
          l = 7'($urandom_range(79));
          t = 5'($urandom_range(24));
          w = 7'($urandom_range(12, 1));
          h = 5'($urandom_range(6, 1));
        end
      endcase
      set_window(l, t, w, h, color, glyph);
      idle_pct = pct[p % 4];
      for (int i = 0; i < count; i++)
        random_cmd(l, t, (w == 0) ? 1 : w, (h == 0) ? 1 : h, big);
    end

    settle();
    if (mirror.fails == 0 && mirror.outstanding() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/twc_pkg.sv
sv/twc_ram.sv
sv/text_window_console.sv
sv/twc_checker.sv
sim/text_window_console_tb.sv
